// ----- sv/periodic_timer_bank_assert.svh -----
// Assertion macros used by the checker of the timer bank.
// Each macro expects clk and rst to be visible where it is used.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ptb_pkg.sv -----
// Shared types and codes of the periodic timer bank.
// No dependencies; imported by every module of the block but ptb_div.
`timescale 1ns / 1ps
package ptb_pkg;

  localparam int CNT_W = 32;

  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_DISARM = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [2:0] ST_FIRED      = 3'd0;
  localparam logic [2:0] ST_ARMED      = 3'd1;
  localparam logic [2:0] ST_ARM_REJ    = 3'd2;
  localparam logic [2:0] ST_DISARMED   = 3'd3;
  localparam logic [2:0] ST_DISARM_IGN = 3'd4;

  typedef struct packed {
    logic latch;
    logic arm;
    logic disarm;
    logic idx_clr;
    logic idx_inc;
    logic rd;
    logic chk;
    logic div_start;
    logic commit;
    logic flush;
  } ptb_cmd_t;

  typedef struct packed {
    logic op_arm;
    logic op_disarm;
    logic op_update;
    logic due;
    logic need_div;
    logic div_done;
    logic idx_last;
  } ptb_stat_t;

endpackage

// ----- sv/ptb_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the timer bank datapath.
`timescale 1ns / 1ps
module ptb_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic         run;
  logic [CW-1:0] cnt;
  logic [W:0]   rem;
  logic [W-1:0] dsr;
  logic [W:0]   rem_sh;
  logic         take;

  assign rem_sh = {rem[W-1:0], quotient[W-1]};
  assign take   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CW'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
      cnt      <= CW'(W);
    end else if (run) begin
      rem      <= take ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quotient <= {quotient[W-2:0], take};
      cnt      <= cnt - CW'(1);
    end
  end
endmodule

// ----- sv/ptb_dp.sv -----
// Datapath of the timer bank: slot flags, period and start memories,
// pending result and output registers. Uses ptb_pkg and ptb_div.
`timescale 1ns / 1ps
module ptb_dp #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ptb_pkg::ptb_cmd_t cmd,
  output ptb_pkg::ptb_stat_t stat,
  input  logic [1:0]        op,
  input  logic [3:0]        slot,
  input  logic [31:0]       period,
  input  logic              repeat_req,
  input  logic              once_only,
  input  logic [31:0]       now,
  output logic              done,
  output logic [3:0]        out_slot,
  output logic [31:0]       fire_count,
  output logic              expired,
  output logic [2:0]        status,
  output logic              last
);
  import ptb_pkg::*;

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW = TIME_WIDTH;

  logic [1:0]    it_op;
  logic [3:0]    it_slot;
  logic [TW-1:0] it_period;
  logic          it_rep;
  logic          it_once;
  logic [TW-1:0] it_now;

  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] rep_f;
  logic [NUM_TIMERS-1:0] once_f;
  logic [TW-1:0] per_mem [NUM_TIMERS];
  logic [TW-1:0] st_mem  [NUM_TIMERS];
  logic [TW-1:0] rd_per;
  logic [TW-1:0] rd_st;

  logic [SW-1:0] idx;
  logic [SW-1:0] a_slot;
  logic          in_range;
  logic          arm_ok;
  logic          dis_hit;
  logic [TW-1:0] elapsed;
  logic          need_div;

  logic          cur_exp;
  logic          cur_one;
  logic          pend_v;
  logic [3:0]    pend_slot;
  logic [CNT_W-1:0] pend_cnt;
  logic          pend_exp;

  logic          div_done;
  logic [TW-1:0] quo;
  logic [CNT_W-1:0] q_sat;
  logic [CNT_W-1:0] cnt;

  assign a_slot   = SW'(it_slot);
  assign in_range = {3'b000, it_slot} < 7'(NUM_TIMERS);
  assign arm_ok   = in_range && (it_period != '0);
  assign dis_hit  = in_range && active[a_slot];
  assign elapsed  = it_now - rd_st;
  assign need_div = rep_f[idx] && !once_f[idx];

  assign stat.op_arm    = it_op == OP_ARM;
  assign stat.op_disarm = it_op == OP_DISARM;
  assign stat.op_update = it_op == OP_UPDATE;
  assign stat.due       = active[idx] && (rd_per != '0) && (elapsed >= rd_per);
  assign stat.need_div  = need_div;
  assign stat.div_done  = div_done;
  assign stat.idx_last  = idx == SW'(NUM_TIMERS - 1);

  ptb_div #(.W(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (elapsed),
    .divisor  (rd_per),
    .done     (div_done),
    .quotient (quo)
  );

  generate
    if (TW > CNT_W) begin : g_sat
      assign q_sat = (|quo[TW-1:CNT_W]) ? '1 : quo[CNT_W-1:0];
    end else begin : g_ext
      assign q_sat = CNT_W'(quo);
    end
  endgenerate

  assign cnt = cur_one ? CNT_W'(1) : q_sat;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      pend_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.arm && arm_ok) begin
        active[a_slot] <= 1'b1;
      end
      if (cmd.disarm && dis_hit) begin
        active[a_slot] <= 1'b0;
      end
      if (cmd.commit && cur_exp) begin
        active[idx] <= 1'b0;
      end
      if (cmd.commit) begin
        pend_v <= 1'b1;
      end else if (cmd.flush) begin
        pend_v <= 1'b0;
      end
      if (cmd.arm || cmd.disarm || ((cmd.commit || cmd.flush) && pend_v)) begin
        done <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_op     <= op;
      it_slot   <= slot;
      it_period <= TW'(period);
      it_rep    <= repeat_req;
      it_once   <= once_only;
      it_now    <= TW'(now);
    end
    if (cmd.arm && arm_ok) begin
      rep_f[a_slot]  <= it_rep;
      once_f[a_slot] <= it_once;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + SW'(1);
    end
    if (cmd.chk) begin
      cur_exp <= !rep_f[idx];
      cur_one <= !need_div;
    end
    if (cmd.commit) begin
      pend_slot <= 4'(idx);
      pend_cnt  <= cnt;
      pend_exp  <= cur_exp;
    end
    if (cmd.arm) begin
      out_slot   <= it_slot;
      fire_count <= '0;
      expired    <= 1'b0;
      status     <= arm_ok ? ST_ARMED : ST_ARM_REJ;
      last       <= 1'b1;
    end else if (cmd.disarm) begin
      out_slot   <= it_slot;
      fire_count <= '0;
      expired    <= 1'b0;
      status     <= dis_hit ? ST_DISARMED : ST_DISARM_IGN;
      last       <= 1'b1;
    end else if (cmd.commit || cmd.flush) begin
      out_slot   <= pend_slot;
      fire_count <= pend_cnt;
      expired    <= pend_exp;
      status     <= ST_FIRED;
      last       <= cmd.flush;
    end
  end

  // Period and start memories: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.arm && arm_ok) begin
      per_mem[a_slot] <= it_period;
      st_mem[a_slot]  <= it_now;
    end else if (cmd.commit && !cur_exp) begin
      st_mem[idx] <= it_now;
    end
    if (cmd.rd) begin
      rd_per <= per_mem[idx];
      rd_st  <= st_mem[idx];
    end
  end
endmodule

// ----- sv/ptb_ctrl.sv -----
// Sequencer of the timer bank: decodes items and steps the slot scan.
// Uses ptb_pkg; drives the datapath through ptb_cmd_t.
`timescale 1ns / 1ps
module ptb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ptb_pkg::ptb_stat_t stat,
  output logic               busy,
  output ptb_pkg::ptb_cmd_t  cmd
);
  import ptb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op_arm) begin
          cmd.arm    = 1'b1;
          state_next = S_IDLE;
        end else if (stat.op_disarm) begin
          cmd.disarm = 1'b1;
          state_next = S_IDLE;
        end else if (stat.op_update) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk = 1'b1;
        if (stat.due) begin
          if (stat.need_div) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_COMMIT;
          end
        end else if (stat.idx_last) begin
          state_next = S_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (stat.idx_last) begin
          state_next = S_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ----- sv/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: sequencer plus datapath.
// Uses ptb_pkg, ptb_ctrl and ptb_dp.
//
// A command beat is taken when start is high and busy is low. Arm and disarm
// beats give one result beat with last set. An update beat scans every slot
// in ascending order: for each slot a memory read, then the due check; for a
// due slot a commit step, preceded by a division in the shared bit-serial
// divider when the slot repeats and counts multiple periods; and a flush
// step at the end. Results come out as single-cycle beats marked by done and
// cannot be held off; the receiver must take every beat in the cycle it
// appears. Each result of an update is held back until the next due slot's
// commit or the final flush, so that the final one can carry last. An update
// with nothing due gives no result, and neither does the unused op code.
`timescale 1ns / 1ps
module periodic_timer_bank #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [3:0]  slot,
  input  logic [31:0] period,
  input  logic        repeat_req,
  input  logic        once_only,
  input  logic [31:0] now,
  output logic        done,
  output logic [3:0]  out_slot,
  output logic [31:0] fire_count,
  output logic        expired,
  output logic [2:0]  status,
  output logic        last
);
  import ptb_pkg::*;

  ptb_cmd_t  cmd;
  ptb_stat_t stat;

  // The sequencer only ever looks at status flags from the datapath.
  ptb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds all slot state and registers every result beat.
  ptb_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .slot       (slot),
    .period     (period),
    .repeat_req (repeat_req),
    .once_only  (once_only),
    .now        (now),
    .done       (done),
    .out_slot   (out_slot),
    .fire_count (fire_count),
    .expired    (expired),
    .status     (status),
    .last       (last)
  );
endmodule

// ----- sv/ptb_check.sv -----
// Port-level checks of the timer bank, bound to the top level.
// Uses ptb_pkg and periodic_timer_bank_assert.svh.
`timescale 1ns / 1ps
`include "periodic_timer_bank_assert.svh"
module ptb_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] fire_count,
  input logic        expired,
  input logic [2:0]  status,
  input logic        last
);
  import ptb_pkg::*;

  `PTB_ASSERT_IMPLY(a_fire_nonzero, done && status == ST_FIRED, fire_count != 32'd0, "fired beat with zero count")
  `PTB_ASSERT_IMPLY(a_cmd_single, done && status != ST_FIRED, last && !expired && fire_count == 32'd0, "bad command result beat")
  `PTB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `PTB_ASSERT_NEXT(a_last_ends, done && last, !done, "beat follows the last one")
endmodule

bind periodic_timer_bank ptb_check u_ptb_check (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .fire_count (fire_count),
  .expired    (expired),
  .status     (status),
  .last       (last)
);
